/* hdl/pcf_pkg.sv */
// PNG chunk framer: shared types, CRC constants and byte helpers.
// No dependencies; used by every framer module except pcf_check.
`default_nettype none
package pcf_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [30:0] chunk_length;
      logic [31:0] chunk_type;
      logic [7:0]  data_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       chunk_end;
   } rsp_type;

   function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   // byte 0 is the most significant one
   function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0: b = w[31:24];
         2'd1: b = w[23:16];
         2'd2: b = w[15:8];
         default: b = w[7:0];
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

/* hdl/png_chunk_framer_crc32.sv */
// Path: input register, sequencer (via its S_LEN state for a start item), output
// register, rsp. Throughput: data items one per cycle unless rsp stalls, set by
// the byte-wide CRC fold; a start item holds the sequencer for its length and type
// bytes (and CRC bytes if the chunk is empty), a last data byte for the CRC bytes.
// The input register holds one further item meanwhile.
// Reset: synchronous, clears the CRC to all ones, closes any open chunk.
`default_nettype none
module png_chunk_framer_crc32 (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // chunk_length[30:0], chunk_type[62:31],
                                         // data_byte[70:63], zero pad [71]
   input  wire logic        req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte[7:0]
   output logic             rsp_tlast    // chunk_end
);

   pcf_pkg::item_type s_item;
   pcf_pkg::item_type cur_item;
   pcf_pkg::rsp_type  emit;
   pcf_pkg::rsp_type  rsp;
   logic              cur_valid;
   logic              cur_take;
   logic              emit_valid;
   logic              emit_ready;

   always_comb begin
      s_item.req_type     = req_tuser;
      s_item.chunk_length = req_tdata[30:0];
      s_item.chunk_type   = req_tdata[62:31];
      s_item.data_byte    = req_tdata[70:63];
   end

   pcf_inreg u_inreg (
      .clock   (clock),
      .reset   (reset),
      .s_valid (req_tvalid),
      .s_ready (req_tready),
      .s_item  (s_item),
      .m_valid (cur_valid),
      .m_item  (cur_item),
      .m_take  (cur_take)
   );

   pcf_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (cur_valid),
      .item       (cur_item),
      .item_take  (cur_take),
      .emit_valid (emit_valid),
      .emit       (emit),
      .emit_ready (emit_ready)
   );

   pcf_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (emit_valid),
      .in_ready  (emit_ready),
      .in_data   (emit),
      .out_valid (rsp_tvalid),
      .out_data  (rsp),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = rsp.out_byte;
   assign rsp_tlast = rsp.chunk_end;

endmodule
`default_nettype wire

/* hdl/pcf_inreg.sv */
// PNG chunk framer: input register stage holding one accepted item.
// Depends on pcf_pkg.
`default_nettype none
module pcf_inreg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              s_valid,
   output logic                   s_ready,
   input  wire pcf_pkg::item_type s_item,
   output logic                   m_valid,
   output pcf_pkg::item_type      m_item,
   input  wire logic              m_take
);

   logic              valid_ff, valid_in;
   pcf_pkg::item_type item_ff, item_in;

   assign s_ready = !valid_ff || m_take;
   assign m_valid = valid_ff;
   assign m_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (s_valid && s_ready) begin
         valid_in = 1'b1;
         item_in  = s_item;
      end else if (m_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule
`default_nettype wire

/* hdl/pcf_seq.sv */
// PNG chunk framer: byte sequencer with the running CRC-32 and chunk state.
// Emits at most one byte per cycle, held while emit_ready is low; depends on pcf_pkg.
`default_nettype none
module pcf_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire pcf_pkg::item_type item,
   output logic                   item_take,
   output logic                   emit_valid,
   output pcf_pkg::rsp_type       emit,
   input  wire logic              emit_ready
);

   typedef enum logic [1:0] {S_IDLE, S_LEN, S_TYP, S_CRC} state_type;

   state_type   state_ff, state_in;
   logic [1:0]  idx_ff, idx_in;
   logic [30:0] len_ff, len_in;
   logic [31:0] typ_ff, typ_in;
   logic [31:0] crc_ff, crc_in;
   logic [30:0] left_ff, left_in;
   logic        in_chunk_ff, in_chunk_in;
   logic        adv;

   assign adv = emit_valid && emit_ready;

   always_comb begin
      item_take   = 1'b0;
      emit_valid  = 1'b0;
      emit        = '0;
      state_in    = state_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      typ_in      = typ_ff;
      crc_in      = crc_ff;
      left_in     = left_ff;
      in_chunk_in = in_chunk_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid && emit_ready) begin
               item_take = 1'b1;
               if (item.req_type == pcf_pkg::REQ_START) begin
                  len_in      = item.chunk_length;
                  typ_in      = item.chunk_type;
                  crc_in      = pcf_pkg::CRC_ONES;
                  left_in     = item.chunk_length;
                  in_chunk_in = 1'b1;
                  idx_in      = 2'd0;
                  state_in    = S_LEN;
               end else if (in_chunk_ff) begin
                  emit_valid    = 1'b1;
                  emit.out_byte = item.data_byte;
                  crc_in        = pcf_pkg::crc_fold(crc_ff, item.data_byte);
                  left_in       = 31'(left_ff - 31'd1);
                  if (left_ff == 31'd1) begin
                     in_chunk_in = 1'b0;
                     idx_in      = 2'd0;
                     state_in    = S_CRC;
                  end
               end
            end
         end
         S_LEN: begin
            emit_valid    = 1'b1;
            emit.out_byte = pcf_pkg::byte_of({1'b0, len_ff}, idx_ff);
            if (adv) begin
               idx_in = 2'(idx_ff + 2'd1);
               if (idx_ff == 2'd3) begin
                  state_in = S_TYP;
               end
            end
         end
         S_TYP: begin
            emit_valid    = 1'b1;
            emit.out_byte = pcf_pkg::byte_of(typ_ff, idx_ff);
            if (adv) begin
               crc_in = pcf_pkg::crc_fold(crc_ff, emit.out_byte);
               idx_in = 2'(idx_ff + 2'd1);
               if (idx_ff == 2'd3) begin
                  if (len_ff == 31'd0) begin
                     in_chunk_in = 1'b0;
                     state_in    = S_CRC;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_CRC: begin
            emit_valid     = 1'b1;
            emit.out_byte  = pcf_pkg::byte_of(~crc_ff, idx_ff);
            emit.chunk_end = (idx_ff == 2'd3);
            if (adv) begin
               idx_in = 2'(idx_ff + 2'd1);
               if (idx_ff == 2'd3) begin
                  crc_in   = pcf_pkg::CRC_ONES;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= 2'd0;
         crc_ff      <= pcf_pkg::CRC_ONES;
         left_ff     <= 31'd0;
         in_chunk_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         crc_ff      <= crc_in;
         left_ff     <= left_in;
         in_chunk_ff <= in_chunk_in;
      end
      len_ff <= len_in;
      typ_ff <= typ_in;
   end

endmodule
`default_nettype wire

/* hdl/pcf_obuf.sv */
// PNG chunk framer: two-entry output register with skid slot.
// Registered ready toward the sequencer; depends on pcf_pkg.
`default_nettype none
module pcf_obuf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire pcf_pkg::rsp_type in_data,
   output logic                  out_valid,
   output pcf_pkg::rsp_type      out_data,
   input  wire logic             out_ready
);

   logic             main_v_ff, main_v_in;
   logic             skid_v_ff, skid_v_in;
   pcf_pkg::rsp_type main_ff, main_in;
   pcf_pkg::rsp_type skid_ff, skid_in;
   logic             push;
   logic             main_free;

   assign in_ready  = !skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_ff;
   assign push      = in_valid && in_ready;
   assign main_free = !main_v_ff || out_ready;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_in   = main_ff;
      skid_in   = skid_ff;
      if (main_free) begin
         if (skid_v_ff) begin
            main_in   = skid_ff;
            main_v_in = 1'b1;
            skid_v_in = 1'b0;
         end else if (push) begin
            main_in   = in_data;
            main_v_in = 1'b1;
         end else begin
            main_v_in = 1'b0;
         end
      end else if (push) begin
         skid_in   = in_data;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
`default_nettype wire

/* hdl/pcf_check.sv */
// PNG chunk framer: port-level checker and its bind to the top level.
// Depends only on the top-level ports of png_chunk_framer_crc32.
`default_nettype none
module pcf_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("framer not empty and ready after reset");

   // a CRC trailer is never directly followed by another chunk end
   a_end_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || !rsp_tlast)
      else $error("two chunk ends in a row");

endmodule

bind png_chunk_framer_crc32 pcf_check u_pcf_check (.*);
`default_nettype wire

/* tb/png_frame_checker.sv */
// Scoreboard for the PNG chunk framer: watches both streams and predicts each output byte.
// It keeps its own copy of the CRC and chunk state and checks rsp items in order.
// Depends on pcf_pkg for the rsp_type struct, the CRC constants and the item kinds.
module png_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [71:0] req_tdata,   // chunk_length[30:0], chunk_type[62:31],
                                         // data_byte[70:63], zero pad [71]
   input  wire logic        req_tuser,   // req_type
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,   // out_byte[7:0]
   input  wire logic        rsp_tlast,   // chunk_end
   output int               pending,
   output int               errors,
   output int               checked
);
   timeunit 1ns;
   timeprecision 1ps;

   pcf_pkg::rsp_type framed_bytes[$];
   pcf_pkg::rsp_type want;
   logic [31:0]      crc_run = pcf_pkg::CRC_ONES;
   logic [30:0]      bytes_due = '0;
   logic             chunk_open = 1'b0;
   int               err_count = 0;
   int               match_count = 0;

   // bit-serial reflected CRC, one data bit per step
   function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] r;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         r = (r >> 1) ^ ((r[0] ^ b[i]) ? pcf_pkg::CRC_POLY : 32'h0);
      end
      return r;
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic last);
      pcf_pkg::rsp_type e;
      e.out_byte  = b;
      e.chunk_end = last;
      framed_bytes = {framed_bytes, e};
   endtask

   task automatic close_chunk();
      logic [31:0] v;
      v = ~crc_run;
      put_byte(v[31:24], 1'b0);
      put_byte(v[23:16], 1'b0);
      put_byte(v[15:8], 1'b0);
      put_byte(v[7:0], 1'b1);
      crc_run    = pcf_pkg::CRC_ONES;
      bytes_due  = '0;
      chunk_open = 1'b0;
   endtask

   task automatic frame_chunk_item(input logic kind, input logic [30:0] len,
                                   input logic [31:0] code, input logic [7:0] dat);
      if (kind == pcf_pkg::REQ_START) begin
         put_byte({1'b0, len[30:24]}, 1'b0);
         put_byte(len[23:16], 1'b0);
         put_byte(len[15:8], 1'b0);
         put_byte(len[7:0], 1'b0);
         crc_run = pcf_pkg::CRC_ONES;
         for (int s = 3; s >= 0; s--) begin
            put_byte(code[s*8 +: 8], 1'b0);
            crc_run = crc32_step(crc_run, code[s*8 +: 8]);
         end
         bytes_due  = len;
         chunk_open = 1'b1;
         if (len == '0) close_chunk();
      end else if (chunk_open) begin
         put_byte(dat, 1'b0);
         crc_run   = crc32_step(crc_run, dat);
         bytes_due = bytes_due - 31'd1;
         if (bytes_due == '0) close_chunk();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         framed_bytes.delete();
         crc_run    = pcf_pkg::CRC_ONES;
         bytes_due  = '0;
         chunk_open = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (framed_bytes.size() == 0) begin
               $display("%0t: rsp item with nothing expected: byte %02h last %0b",
                        $time, rsp_tdata, rsp_tlast);
               err_count++;
            end else begin
               want = framed_bytes.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $display("%0t: out_byte mismatch: expected %02h actual %02h",
                           $time, want.out_byte, rsp_tdata);
                  err_count++;
               end
               if (rsp_tlast !== want.chunk_end) begin
                  $display("%0t: chunk_end mismatch: expected %0b actual %0b",
                           $time, want.chunk_end, rsp_tlast);
                  err_count++;
               end
               match_count++;
            end
         end
         if (req_tvalid && req_tready)
            frame_chunk_item(req_tuser, req_tdata[30:0], req_tdata[62:31], req_tdata[70:63]);
      end
      pending <= framed_bytes.size();
      errors  <= err_count;
      checked <= match_count;
   end

endmodule

/* tb/tb_top.sv */
// Testbench top for png_chunk_framer_crc32: clock, reset, stimulus, rsp back-pressure and verdict.
// Directed chunks first, then random chunks with random gaps on both sides.
// Depends on pcf_pkg, the framer RTL and png_frame_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 1000;
   localparam int RANDOM_ITEMS = 170;
   localparam int MAX_GAP      = 14;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   int pending;
   int errors;
   int checked;
   int idle_cycles = 0;

   logic        send_calm = 1'b0;
   logic        recv_calm = 1'b0;
   logic        shadow_open = 1'b0;
   logic [30:0] shadow_left = '0;
   int          n_items = 0;
   int          n_starts = 0;
   int          n_empty = 0;
   int          n_abandon = 0;
   int          n_stray = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   png_chunk_framer_crc32 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   png_frame_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .pending    (pending),
      .errors     (errors),
      .checked    (checked)
   );

   function automatic logic [30:0] rand_len();
      logic [31:0] w;
      w = $urandom;
      return w[30:0];
   endfunction

   function automatic logic [7:0] rand_byte();
      logic [31:0] w;
      w = $urandom;
      return w[7:0];
   endfunction

   task automatic send_item(input logic kind, input logic [30:0] len,
                            input logic [31:0] code, input logic [7:0] dat);
      int gap;
      if ($urandom_range(0, 19) == 0) send_calm = ~send_calm;
      gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {1'b0, dat, code, len};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (kind == pcf_pkg::REQ_START) begin
         n_starts++;
         n_items++;
         if (shadow_open) n_abandon++;
         if (len == '0) n_empty++;
         shadow_open = (len != '0);
         shadow_left = len;
      end else if (shadow_open) begin
         n_items++;
         shadow_left = shadow_left - 31'd1;
         shadow_open = (shadow_left != '0);
      end else begin
         n_stray++;
      end
   endtask

   task automatic send_payload(input logic [7:0] dat);
      send_item(pcf_pkg::REQ_DATA, rand_len(), $urandom, dat);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // one chunk: mostly complete, some cut short by the next start, now and then huge
   task automatic random_chunk();
      int          r;
      int          body;
      logic [30:0] length;
      r = $urandom_range(0, 99);
      if (r < 15)
         length = '0;
      else if (r < 70)
         length = 31'($urandom_range(1, 6));
      else if (r < 88)
         length = 31'($urandom_range(7, 20));
      else
         length = rand_len();
      body = (length > 20) ? $urandom_range(0, 3) : int'(length);
      if (length != '0 && length <= 20 && $urandom_range(0, 9) == 0)
         body = $urandom_range(0, int'(length) - 1);
      send_item(pcf_pkg::REQ_START, length, $urandom, rand_byte());
      repeat (body) send_payload(rand_byte());
      if (!shadow_open && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 2)) send_payload(rand_byte());
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= pcf_pkg::REQ_START;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // stray data before any chunk
      send_item(pcf_pkg::REQ_DATA, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
      // empty chunks
      send_item(pcf_pkg::REQ_START, 31'd0, 32'h4945_4E44, 8'hFF);
      send_item(pcf_pkg::REQ_START, 31'd0, 32'hFFFF_FFFF, 8'h00);
      send_item(pcf_pkg::REQ_START, 31'd0, 32'h0000_0000, 8'hA5);
      // one and three byte payloads, unused fields loaded
      send_item(pcf_pkg::REQ_START, 31'd1, 32'h4948_4452, 8'h3C);
      send_item(pcf_pkg::REQ_DATA, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'h00);
      send_item(pcf_pkg::REQ_START, 31'd3, 32'h4944_4154, 8'h00);
      send_payload(8'hFF);
      send_payload(8'h00);
      send_payload(8'hA5);
      send_item(pcf_pkg::REQ_DATA, 31'd0, 32'h0000_0000, 8'h5A);
      // maximum length, then abandoned by new starts
      send_item(pcf_pkg::REQ_START, 31'h7FFF_FFFF, 32'h7445_5874, 8'hC3);
      send_payload(8'h12);
      send_payload(8'h34);
      send_item(pcf_pkg::REQ_START, 31'd2, 32'hA5A5_A5A5, 8'h77);
      send_payload(8'h80);
      send_payload(8'h01);
      send_item(pcf_pkg::REQ_START, 31'd4, 32'h5A5A_5A5A, 8'h11);
      send_payload(8'hFE);
      send_item(pcf_pkg::REQ_START, 31'd0, 32'h1234_5678, 8'h22);
      send_item(pcf_pkg::REQ_START, 31'h5555_5555, 32'h5555_5555, 8'h55);
      send_item(pcf_pkg::REQ_START, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 8'hAA);
      send_item(pcf_pkg::REQ_START, 31'd1, 32'h7445_5874, 8'h00);
      send_payload(8'h7F);

      hold_until_drained();

      while (n_items < RANDOM_ITEMS) begin
         random_chunk();
         if ($urandom_range(0, 24) == 0) hold_until_drained();
      end

      hold_until_drained();
      repeat (20) @(posedge clock);

      $display("run: %0d chunk starts (%0d empty, %0d cut short), %0d payload items, %0d strays",
               n_starts, n_empty, n_abandon, n_items - n_starts, n_stray);
      $display("run: %0d output bytes compared, %0d mismatches", checked, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // rsp back-pressure, drawn per item
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 24) == 0) recv_calm = ~recv_calm;
         stall = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t: no item moved for %0d cycles, %0d bytes still expected",
                  $time, IDLE_LIMIT, pending);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

/* sim.f */
hdl/pcf_pkg.sv
hdl/pcf_inreg.sv
hdl/pcf_seq.sv
hdl/pcf_obuf.sv
hdl/png_chunk_framer_crc32.sv
hdl/pcf_check.sv
tb/png_frame_checker.sv
tb/tb_top.sv
